FILE: sv/dtd_pkg.sv
package dtd_pkg;

	localparam int unsigned FB_W    = 24;
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned DISP_W  = 16;
	localparam int unsigned DEPTH_W = 16;
	localparam int unsigned CFG_W   = 24;
	localparam int unsigned IDX_W   = 2;

	// divisor of a bound: distance plus correction, one bit wider than the distance
	localparam int unsigned BDIV_W  = DIST_W + 1;
	// largest bound is the largest product over the correction
	localparam int unsigned BOUND_W = 14;

	localparam logic [BDIV_W-1:0]  DIST_CORR  = BDIV_W'(1500);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX  = DEPTH_W'(65535);
	localparam logic [FB_W-1:0]    FB_RESET   = FB_W'(12821030);
	localparam logic [DIST_W-1:0]  NEAR_RESET = DIST_W'(5000);
	localparam logic [DIST_W-1:0]  FAR_RESET  = DIST_W'(16560);

	// quotient bits resolved by each stage of the depth divider
	localparam int unsigned SPS  = 4;
	localparam int unsigned NDIV = FB_W / SPS;

	typedef enum logic [IDX_W-1:0] {
		REG_FOCAL_BASELINE = 2'd0,
		REG_NEAR_DISTANCE  = 2'd1,
		REG_FAR_DISTANCE   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [DISP_W-1:0] dvs;
		logic [DISP_W-1:0] rem;
		logic [FB_W-1:0]   quo;
		logic              kill;
	} stage_t;

endpackage

FILE: sv/dtd_seq_div.sv
module dtd_seq_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dtd_pkg::FB_W-1:0]      dividend,
	input  logic [dtd_pkg::BDIV_W-1:0]    divisor,
	output logic                          busy,
	output logic [dtd_pkg::BOUND_W-1:0]   quotient
);
	import dtd_pkg::*;

	localparam int unsigned CNT_W = $clog2(FB_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BDIV_W-1:0] div_q;
	logic [BDIV_W-1:0] rem_q;
	logic [FB_W-1:0]   quo_q;
	logic [BDIV_W:0]   trial;
	logic              ge;

	// restoring division, one quotient bit per cycle, dividend shifts out the top
	assign trial = {rem_q, quo_q[FB_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(FB_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? BDIV_W'(trial - {1'b0, div_q}) : trial[BDIV_W-1:0];
			quo_q <= {quo_q[FB_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q[BOUND_W-1:0];

endmodule

FILE: sv/disparity_to_depth_convert.sv
// Converts one stereo disparity word per beat into a depth in millimetres: the
// focal-baseline product divided by the disparity, truncated and saturated at 65535.
// A disparity outside the window set by the near and far distances (each plus a
// 1500 mm correction, turned into disparity bounds by dividing the product by
// them), or a disparity of zero, gives 0. One pixel enters per cycle while in_stall
// is low; each taken beat passes eight registers on its way to a result (input
// register, six divider stages that resolve four quotient bits each, output
// register). Each stage holds its beat under out_stall and passes it on as soon as
// the stage ahead has room, so bubbles close up. The bounds come from two bit-serial
// dividers that run after reset and after every configuration write; in_stall
// stays high while they run.
// Write configuration only with no beats in flight.
module disparity_to_depth_convert (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [dtd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [dtd_pkg::CFG_W-1:0]     cfg_data,
	// disparity in
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dtd_pkg::DISP_W-1:0]    disparity,
	// depth out
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dtd_pkg::DEPTH_W-1:0]   depth_mm
);
	import dtd_pkg::*;

	// configuration registers and bound dividers
	logic [FB_W-1:0]    fb_q;
	logic [DIST_W-1:0]  near_q;
	logic [DIST_W-1:0]  far_q;
	logic               start_q;
	logic               near_busy;
	logic               far_busy;
	logic [BOUND_W-1:0] near_bound;
	logic [BOUND_W-1:0] far_bound;

	// pipeline
	logic               valid_s [0:NDIV];
	stage_t             stage_s [0:NDIV];
	logic               load    [0:NDIV];
	logic               load_out;
	logic               out_valid_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               in_beat;
	logic               in_kill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q    <= FB_RESET;
			near_q  <= NEAR_RESET;
			far_q   <= FAR_RESET;
			start_q <= 1'b1;
		end else begin
			// kick the bound dividers in the cycle after any write, once the value has landed
			start_q <= cfg_wr_en;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_FOCAL_BASELINE: fb_q   <= cfg_data[FB_W-1:0];
					REG_NEAR_DISTANCE:  near_q <= cfg_data[DIST_W-1:0];
					REG_FAR_DISTANCE:   far_q  <= cfg_data[DIST_W-1:0];
					default: ;
				endcase
			end
		end
	end

	dtd_seq_div u_near_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (fb_q),
		.divisor  ({1'b0, near_q} + DIST_CORR),
		.busy     (near_busy),
		.quotient (near_bound)
	);

	dtd_seq_div u_far_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (fb_q),
		.divisor  ({1'b0, far_q} + DIST_CORR),
		.busy     (far_busy),
		.quotient (far_bound)
	);

	// A stage takes a new beat when it is empty or its own beat moves on.
	assign load_out = !out_valid_q || !out_stall;

	always_comb begin
		load[NDIV] = !valid_s[NDIV] || load_out;
		for (int k = NDIV - 1; k >= 0; k--) begin
			load[k] = !valid_s[k] || load[k+1];
		end
	end

	assign in_stall = start_q || near_busy || far_busy || !load[0];
	assign in_beat  = in_valid && !in_stall;

	// Drop to zero outside the bound window and on a zero disparity.
	assign in_kill = (disparity < {{(DISP_W-BOUND_W){1'b0}}, far_bound})
		|| (disparity > {{(DISP_W-BOUND_W){1'b0}}, near_bound})
		|| (disparity == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (load[0]) begin
			valid_s[0] <= in_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			stage_s[0] <= '{dvs: disparity, rem: '0, quo: '0, kill: in_kill};
		end
	end

	// Divider stages: restoring division of the product by the disparity,
	// dividend bits taken from the top down, SPS of them per stage.
	for (genvar k = 1; k <= NDIV; k++) begin : g_div
		logic [DISP_W-1:0] rem_n;
		logic [SPS-1:0]    qb_n;

		always_comb begin
			logic [DISP_W:0] trial;
			rem_n = stage_s[k-1].rem;
			qb_n  = '0;
			for (int j = 0; j < SPS; j++) begin
				trial = {rem_n, fb_q[FB_W-1-(k-1)*SPS-j]};
				if (trial >= {1'b0, stage_s[k-1].dvs}) begin
					rem_n           = DISP_W'(trial - {1'b0, stage_s[k-1].dvs});
					qb_n[SPS-1-j]   = 1'b1;
				end else begin
					rem_n           = trial[DISP_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (load[k]) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (load[k]) begin
				stage_s[k] <= '{
					dvs:  stage_s[k-1].dvs,
					rem:  rem_n,
					quo:  {stage_s[k-1].quo[FB_W-SPS-1:0], qb_n},
					kill: stage_s[k-1].kill
				};
			end
		end
	end

	// Output register: zero on kill, clamp anything past 16 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= valid_s[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (stage_s[NDIV].kill) begin
				depth_q <= '0;
			end else if (|stage_s[NDIV].quo[FB_W-1:DEPTH_W]) begin
				depth_q <= DEPTH_MAX;
			end else begin
				depth_q <= stage_s[NDIV].quo[DEPTH_W-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign depth_mm  = depth_q;

	// Both bound dividers start together and run the same count.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		near_busy == far_busy)
		else $error("bound dividers out of step");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> near_busy)
		else $error("bound divider did not start");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[0] && valid_s[1] && valid_s[2] && valid_s[3] && valid_s[4]
			&& valid_s[5] && valid_s[6] && out_valid && out_stall) |-> in_stall)
		else $error("input taken with full pipeline");

	a_kill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[NDIV] && load_out && stage_s[NDIV].kill) |=> (depth_mm == '0))
		else $error("out-of-window pixel gave nonzero depth");

endmodule

FILE: verif/disparity_to_depth_convert_test.sv
module disparity_to_depth_convert_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dtd_pkg::*;

	// index 3 decodes to no register; a write there must change nothing
	localparam logic [IDX_W-1:0] REG_UNMAPPED = IDX_W'(3);

	localparam int unsigned RANDOM_BEATS = 1750;
	localparam int unsigned PHASES       = 7;
	localparam int unsigned LONG_HOLD    = 80;
	// eight stages from input beat to depth beat, plus some margin
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam longint unsigned CYCLE_LIMIT = 200000;

	// Depth predictor and ordered store of expected depths.
	class depth_scoreboard;
		logic [FB_W-1:0]    focal_baseline;
		logic [DIST_W-1:0]  near_mm;
		logic [DIST_W-1:0]  far_mm;
		logic [DEPTH_W-1:0] depth_q[$];
		int unsigned        failures;

		function new();
			focal_baseline = FB_RESET;
			near_mm        = NEAR_RESET;
			far_mm         = FAR_RESET;
			failures       = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
			case (index)
			REG_FOCAL_BASELINE: focal_baseline = data[FB_W-1:0];
			REG_NEAR_DISTANCE:  near_mm        = data[DIST_W-1:0];
			REG_FAR_DISTANCE:   far_mm         = data[DIST_W-1:0];
			default: ;
			endcase
		endfunction

		// largest disparity still inside the window
		function int unsigned near_bound();
			return focal_baseline / (near_mm + DIST_CORR);
		endfunction

		// smallest disparity still inside the window
		function int unsigned far_bound();
			return focal_baseline / (far_mm + DIST_CORR);
		endfunction

		function logic [DEPTH_W-1:0] depth_for(logic [DISP_W-1:0] disp);
			int unsigned quot;
			if (disp == 0 || disp < far_bound() || disp > near_bound())
				return '0;
			quot = focal_baseline / disp;
			if (quot > DEPTH_MAX)
				return DEPTH_MAX;
			return quot[DEPTH_W-1:0];
		endfunction

		function void note_disparity(logic [DISP_W-1:0] disp);
			depth_q.insert(depth_q.size(), depth_for(disp));
		endfunction

		function void check_depth(logic [DEPTH_W-1:0] got);
			logic [DEPTH_W-1:0] want;
			if (depth_q.size() == 0) begin
				failures++;
				$display("%0t: depth_mm expected none, got %0d", $time, got);
				return;
			end
			want = depth_q.pop_front();
			if (got !== want) begin
				failures++;
				$display("%0t: depth_mm expected %0d, got %0d", $time, want, got);
			end
		endfunction

		function int unsigned pending();
			return depth_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [DISP_W-1:0]  disparity;
	logic               out_valid;
	logic               out_stall;
	logic [DEPTH_W-1:0] depth_mm;

	depth_scoreboard sb = new();

	// stall rates in percent; updated with nonblocking writes at a falling edge so
	// that the stall generator always sees a settled value
	int unsigned send_idle_pct = 24;
	int unsigned recv_idle_pct = 69;
	bit          long_hold_done = 1'b0;

	disparity_to_depth_convert DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.disparity (disparity),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.depth_mm  (depth_mm)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// All stimulus tasks start and end at a falling edge.

	// Pulse one register write, then mirror it into the predictor.
	task automatic write_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		sb.write_reg(index, data);
	endtask

	// Drop valid, hold off until every depth has come back, then let the pipe empty.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Reprogram all three registers with the block idle. The distance registers are
	// narrower than the write bus, so fill the spare bits with noise.
	task automatic set_window(logic [FB_W-1:0] fb, logic [DIST_W-1:0] near_v,
			logic [DIST_W-1:0] far_v);
		logic [CFG_W-1:0] word;
		drain_results();
		write_reg(REG_FOCAL_BASELINE, CFG_W'(fb));
		word = CFG_W'($urandom());
		word[DIST_W-1:0] = near_v;
		write_reg(REG_NEAR_DISTANCE, word);
		word = CFG_W'($urandom());
		word[DIST_W-1:0] = far_v;
		write_reg(REG_FAR_DISTANCE, word);
	endtask

	// Offer one disparity beat, with random idle cycles in front, and hold it
	// until the block takes it.
	task automatic send_disparity(logic [DISP_W-1:0] disp);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		disparity <= disp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_disparity(disp);
		@(negedge clk);
	endtask

	// Hit both sides of each window bound, plus the two extremes of the field.
	task automatic probe_bounds();
		int unsigned lo;
		int unsigned hi;
		lo = sb.far_bound();
		hi = sb.near_bound();
		send_disparity('0);
		send_disparity('1);
		send_disparity(DISP_W'(lo - 1));
		send_disparity(DISP_W'(lo));
		send_disparity(DISP_W'(hi));
		send_disparity(DISP_W'(hi + 1));
	endtask

	// Mostly disparities inside the current window, some within two of its bounds, and
	// the rest anywhere in the 16-bit range.
	function automatic logic [DISP_W-1:0] pick_disparity();
		int unsigned lo;
		int unsigned hi;
		int unsigned roll;
		int unsigned rim;
		lo = sb.far_bound();
		hi = sb.near_bound();
		roll = $urandom_range(99);
		if (roll < 60 && lo <= hi)
			return DISP_W'($urandom_range(hi, lo));
		if (roll < 80) begin
			rim = $urandom_range(1) ? lo : hi;
			return DISP_W'(rim + $urandom_range(4) - 2);
		end
		return DISP_W'($urandom());
	endfunction

	// One window setting per random phase, reset window and extremes first, then random spreads.
	task automatic pick_window(int unsigned phase);
		logic [FB_W-1:0]   fb;
		logic [DIST_W-1:0] near_v;
		logic [DIST_W-1:0] far_v;
		case (phase)
		0: begin
			fb     = FB_RESET;
			near_v = NEAR_RESET;
			far_v  = FAR_RESET;
		end
		1: begin
			fb     = '1;
			near_v = '0;
			far_v  = '1;
		end
		2: begin
			// full-range values, crossed windows included
			fb     = FB_W'($urandom());
			near_v = DIST_W'($urandom());
			far_v  = DIST_W'($urandom());
		end
		3: begin
			fb     = FB_W'($urandom_range(200000, 1));
			near_v = DIST_W'($urandom_range(3000));
			far_v  = near_v + DIST_W'($urandom_range(8000));
		end
		5: begin
			// tiny product: window starts at zero disparity
			fb     = FB_W'($urandom_range(40000, 1));
			near_v = '0;
			far_v  = '1;
		end
		default: begin
			fb     = FB_W'($urandom());
			near_v = DIST_W'($urandom_range(20000));
			far_v  = near_v + DIST_W'($urandom_range(40000));
		end
		endcase
		set_window(fb, near_v, far_v);
	endtask

	// Receiver: stall at the current rate. Once, when neither side idles any more,
	// hold off for a long stretch while the sender keeps offering, so that the
	// pipe fills and in_stall rises.
	initial begin : stall_gen
		int unsigned hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!long_hold_done && arst_n && in_valid &&
					send_idle_pct == 0 && recv_idle_pct == 0) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Compare every depth beat the block hands over.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_depth(depth_mm);
	end

	// Watchdog: end the run if it hangs.
	initial begin : watchdog
		longint unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("disparity_to_depth_convert: mismatch");
		$finish;
	end

	initial begin : stimulus
		int unsigned sent;
		int unsigned mode;
		sent      = 0;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_FOCAL_BASELINE;
		cfg_data  = '0;
		in_valid  = 1'b0;
		disparity = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset window: bounds and field extremes
		probe_bounds();

		// largest product, widest window: small disparities saturate at 65535;
		// 255 is the last one that does, 256 gives exactly 65535
		set_window('1, '0, '1);
		probe_bounds();
		send_disparity(DISP_W'(255));
		send_disparity(DISP_W'(256));

		// zero product: both bounds are zero, every depth is zero
		set_window('0, NEAR_RESET, FAR_RESET);
		send_disparity('0);
		send_disparity(DISP_W'(1));
		send_disparity('1);

		// zero disparity gets through the bounds and must still give zero
		set_window(FB_W'(1000), '0, '0);
		send_disparity('0);
		send_disparity(DISP_W'(1));

		// crossed window: near and far swapped, nothing passes; also poke the
		// unmapped index, which must leave the window alone
		set_window(FB_RESET, FAR_RESET, NEAR_RESET);
		write_reg(REG_UNMAPPED, '1);
		probe_bounds();

		// random part: first a slow receiver, then a slow sender, then full rate
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			pick_window(phase);
			if (phase == 2)
				write_reg(REG_UNMAPPED, CFG_W'($urandom()));
			for (int unsigned k = 0; k < RANDOM_BEATS / PHASES; k++) begin
				mode = sent * 3 / RANDOM_BEATS;
				case (mode)
				0: begin
					send_idle_pct <= 24;
					recv_idle_pct <= 69;
				end
				1: begin
					send_idle_pct <= 69;
					recv_idle_pct <= 24;
				end
				default: begin
					send_idle_pct <= 0;
					recv_idle_pct <= 0;
				end
				endcase
				sent++;
				send_disparity(pick_disparity());
			end
		end

		// wait for the last depths, then give stray beats time to show up
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.failures == 0)
			$display("disparity_to_depth_convert: match");
		else
			$display("disparity_to_depth_convert: mismatch");
		$finish;
	end

endmodule

FILE: files.f
sv/dtd_pkg.sv
sv/dtd_seq_div.sv
sv/disparity_to_depth_convert.sv
verif/disparity_to_depth_convert_test.sv
